FILE: sv/trwm_pkg.sv
// ----------------------------------------------------------------------------
// trwm_pkg
// Shared types and opcodes for the timestamp ring with window match.
// ----------------------------------------------------------------------------
package trwm_pkg;

  // Operation codes carried in a request.
  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_PEEK    = 3'd1;
  localparam logic [2:0] OP_CONSUME = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_SNAP    = 3'd4;

  // One input request.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] stamp;
    logic [63:0] window;
  } req_t;

  // One result item.
  typedef struct packed {
    logic        hit;
    logic [63:0] entry_stamp;
    logic [63:0] entry_age;
    logic        last;
  } rsp_t;

  // Outcome of comparing one stored stamp with the current time.
  typedef struct packed {
    logic        in_win;
    logic [63:0] age;
  } match_t;

endpackage

FILE: sv/trwm_mem.sv
// ----------------------------------------------------------------------------
// trwm_mem
// Stamp store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trwm_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o
);

  logic [63:0] mem_q [DEPTH];
  logic [63:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/trwm_match.sv
// ----------------------------------------------------------------------------
// trwm_match
// Age of a stored stamp against the current time and the window test.
// ----------------------------------------------------------------------------
module trwm_match (
  input  logic [63:0]           entry_i,
  input  logic [63:0]           now_i,
  input  logic [63:0]           window_i,
  output trwm_pkg::match_t      result_o
);
  import trwm_pkg::*;

  logic [64:0] diff;

  // A borrow out means the stored stamp lies in the future.
  assign diff = {1'b0, now_i} - {1'b0, entry_i};

  assign result_o.in_win = !diff[64] && (diff[63:0] <= window_i);
  assign result_o.age    = diff[64] ? 64'd0 : diff[63:0];

endmodule

FILE: sv/timestamp_ring_window_match.sv
// ----------------------------------------------------------------------------
// timestamp_ring_window_match
// Ring of up to DEPTH timestamps, oldest first, with push, peek, consume,
// clear and snapshot operations.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid_i/in_req_i and are taken when in_stall_o
// is low; results leave on out_valid_o/out_rsp_o and are taken when
// out_stall_i is low. Push and clear complete in the cycle they are taken and
// give no result. Peek and consume read the store one entry per cycle, oldest
// first, from a single read port with registered read data. Consume then
// moves each later entry down one slot before its result. Snapshot gives one
// result per entry, one per cycle while the receiver does not stall, the last
// marked; an empty ring gives one result with hit low.
// One request is worked on at a time; in_stall_o is high while it is.
// A finished result waits in the output register while the next request is
// taken. When the receiver stalls, the result holds and a snapshot scan
// pauses. Reset empties the ring; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module timestamp_ring_window_match #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  trwm_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output trwm_pkg::rsp_t   out_rsp_o
);
  import trwm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] cur_slot_q, cur_slot_d;
  logic [AW-1:0] prev_slot_q, prev_slot_d;
  logic [2:0]    op_q, op_d;
  logic          hit_q, hit_d;
  logic [63:0]   now_q, now_d;
  logic [63:0]   window_q, window_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_q, out_d;

  logic          accept;
  logic          out_free;
  logic          last_pos;
  logic [AW-1:0] next_slot;
  logic [AW:0]   push_sum;
  logic [AW-1:0] push_slot;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_data;
  match_t        cmp;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_pos = (CW'(pos_q) + CW'(1)) == fill_q;

  // Next physical slot with wrap.
  assign next_slot = (cur_slot_q == LAST_SLOT) ? '0 : cur_slot_q + AW'(1);

  // Slot just past the newest entry; the sum stays below twice the depth.
  assign push_sum  = {1'b0, oldest_q} + (AW + 1)'(fill_q);
  assign push_slot = (push_sum >= DEPTH_W) ? AW'(push_sum - DEPTH_W) : push_sum[AW-1:0];

  trwm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  trwm_match u_match (
    .entry_i  (rd_data),
    .now_i    (now_q),
    .window_i (window_q),
    .result_o (cmp)
  );

  // Sequencer: takes requests, walks the ring and shifts after a consume.
  always_comb begin
    state_d     = state_q;
    oldest_d    = oldest_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    cur_slot_d  = cur_slot_q;
    prev_slot_d = prev_slot_q;
    op_d        = op_q;
    hit_d       = hit_q;
    now_d       = now_q;
    window_d    = window_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = push_slot;
    wr_data     = in_req_i.stamp;
    rd_en       = 1'b0;
    rd_addr     = next_slot;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = in_req_i.opcode;
          now_d    = in_req_i.stamp;
          window_d = in_req_i.window;
          case (in_req_i.opcode) inside
            OP_PUSH: begin
              wr_en = 1'b1;
              if (fill_q == FULL_CNT) begin
                wr_addr  = oldest_q;
                oldest_d = (oldest_q == LAST_SLOT) ? '0 : oldest_q + AW'(1);
              end else begin
                fill_d = fill_q + CW'(1);
              end
            end
            OP_CLEAR: begin
              oldest_d = '0;
              fill_d   = '0;
            end
            OP_PEEK, OP_CONSUME, OP_SNAP: begin
              if (fill_q == '0) begin
                hit_d   = 1'b0;
                state_d = ST_RESP;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = oldest_q;
                cur_slot_d = oldest_q;
                pos_d      = '0;
                state_d    = ST_EVAL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_EVAL: begin
        if (op_q == OP_SNAP) begin
          // One result per entry, paced by the receiver.
          if (out_free) begin
            out_valid_d       = 1'b1;
            out_d.hit         = 1'b1;
            out_d.entry_stamp = rd_data;
            out_d.entry_age   = cmp.age;
            out_d.last        = last_pos;
            if (last_pos) begin
              state_d = ST_IDLE;
            end else begin
              rd_en       = 1'b1;
              cur_slot_d  = next_slot;
              prev_slot_d = cur_slot_q;
              pos_d       = pos_q + AW'(1);
            end
          end
        end else if (cmp.in_win) begin
          hit_d = 1'b1;
          if (op_q == OP_CONSUME && !last_pos) begin
            // Later entries move down over the removed one.
            rd_en       = 1'b1;
            cur_slot_d  = next_slot;
            prev_slot_d = cur_slot_q;
            pos_d       = pos_q + AW'(1);
            state_d     = ST_SHIFT;
          end else begin
            if (op_q == OP_CONSUME) begin
              fill_d = fill_q - CW'(1);
            end
            state_d = ST_RESP;
          end
        end else if (last_pos) begin
          hit_d   = 1'b0;
          state_d = ST_RESP;
        end else begin
          rd_en       = 1'b1;
          cur_slot_d  = next_slot;
          prev_slot_d = cur_slot_q;
          pos_d       = pos_q + AW'(1);
        end
      end

      ST_SHIFT: begin
        // Read data holds the entry at pos; it goes one slot down.
        wr_en   = 1'b1;
        wr_addr = prev_slot_q;
        wr_data = rd_data;
        if (last_pos) begin
          fill_d  = fill_q - CW'(1);
          state_d = ST_RESP;
        end else begin
          rd_en       = 1'b1;
          cur_slot_d  = next_slot;
          prev_slot_d = cur_slot_q;
          pos_d       = pos_q + AW'(1);
        end
      end

      ST_RESP: begin
        // Single result of a peek, a consume or an empty snapshot.
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.hit         = hit_q;
          out_d.entry_stamp = '0;
          out_d.entry_age   = '0;
          out_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the request in progress and the result.
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cur_slot_q  <= cur_slot_d;
    prev_slot_q <= prev_slot_d;
    op_q        <= op_d;
    hit_q       <= hit_d;
    now_q       <= now_d;
    window_q    <= window_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The fill count never passes the depth and the oldest slot stays in range.
  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= FULL_CNT) && (oldest_q <= LAST_SLOT))
    else $error("ring fill count or oldest slot out of range");

  // A push into a full ring keeps it full.
  a_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.opcode == OP_PUSH && fill_q == FULL_CNT) |=> (fill_q == FULL_CNT))
    else $error("push into full ring changed the fill count");

  // The store is written only by a push or during a shift.
  a_write_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == ST_IDLE && accept && in_req_i.opcode == OP_PUSH) ||
               state_q == ST_SHIFT))
    else $error("unexpected store write");

  // A consume that shifts always removes one entry on its way out.
  a_shift_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && state_d == ST_RESP) |=> (fill_q == $past(fill_q) - CW'(1)))
    else $error("consume did not remove an entry");

endmodule

FILE: dv/trwm_checker.sv
// ----------------------------------------------------------------------------
// trwm_checker
// Watches both channels of the timestamp ring, keeps its own copy of the ring,
// works out the results each accepted request should give and compares every
// accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module trwm_checker #(
  parameter int DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  trwm_pkg::req_t   in_req_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  trwm_pkg::rsp_t   out_rsp_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_o,
  output int unsigned      results_o
);

  import trwm_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  // Shadow copy of the ring and the results still owed by the block.
  logic [63:0] ring_mem [DEPTH];
  int unsigned ring_head;
  int unsigned ring_fill;
  rsp_t        owed_rsp_q [$];

  int unsigned mismatches = 0;
  int unsigned checked    = 0;
  int unsigned owed       = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = owed;
  assign results_o        = checked;

  // A stored stamp matches when it is not in the future and not too old.
  function automatic logic stamp_in_window(logic [63:0] ts, logic [63:0] now,
                                           logic [63:0] win);
    return (now >= ts) && ((now - ts) <= win);
  endfunction

  function automatic int unsigned ring_slot(int unsigned pos);
    return (ring_head + pos) % DEPTH;
  endfunction

  function automatic rsp_t make_rsp(logic hit, logic [63:0] st, logic [63:0] age,
                                    logic last);
    rsp_t r;
    r.hit         = hit;
    r.entry_stamp = st;
    r.entry_age   = age;
    r.last        = last;
    return r;
  endfunction

  // Append one owed result behind those already waiting.
  function automatic void owe_result(input rsp_t r);
    owed_rsp_q.insert(owed_rsp_q.size(), r);
  endfunction

  // Apply one request to the shadow ring and queue the results it gives.
  task automatic predict_ring_op(input req_t r);
    logic        found;
    int unsigned pos;
    int unsigned k;
    logic [63:0] ts;
    logic [63:0] age;
    found = 1'b0;
    case (r.opcode)
      OP_PUSH: begin
        if (ring_fill < DEPTH) begin
          ring_mem[ring_slot(ring_fill)] = r.stamp;
          ring_fill++;
        end else begin
          // Full ring: the oldest entry is overwritten and the head moves on.
          ring_mem[ring_head] = r.stamp;
          ring_head = (ring_head + 1) % DEPTH;
        end
      end
      OP_PEEK: begin
        for (pos = 0; pos < ring_fill && !found; pos++) begin
          if (stamp_in_window(ring_mem[ring_slot(pos)], r.stamp, r.window)) begin
            found = 1'b1;
          end
        end
        owe_result(make_rsp(found, '0, '0, 1'b1));
      end
      OP_CONSUME: begin
        for (pos = 0; pos < ring_fill && !found; pos++) begin
          if (stamp_in_window(ring_mem[ring_slot(pos)], r.stamp, r.window)) begin
            // Close the gap left by the oldest match.
            for (k = pos + 1; k < ring_fill; k++) begin
              ring_mem[ring_slot(k - 1)] = ring_mem[ring_slot(k)];
            end
            found = 1'b1;
          end
        end
        if (found) begin
          ring_fill--;
        end
        owe_result(make_rsp(found, '0, '0, 1'b1));
      end
      OP_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
      end
      OP_SNAP: begin
        if (ring_fill == 0) begin
          owe_result(make_rsp(1'b0, '0, '0, 1'b1));
        end else begin
          for (pos = 0; pos < ring_fill; pos++) begin
            ts  = ring_mem[ring_slot(pos)];
            age = (r.stamp >= ts) ? (r.stamp - ts) : '0;
            owe_result(make_rsp(1'b1, ts, age, pos + 1 == ring_fill));
          end
        end
      end
      default: begin
        // Spare opcodes leave the ring untouched and give nothing.
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH %0d at %0t (%s): expected hit=%b stamp=%h age=%h last=%b,",
               mismatches, $realtime, what, want.hit, want.entry_stamp, want.entry_age,
               want.last);
      $display("  got hit=%b stamp=%h age=%h last=%b",
               got.hit, got.entry_stamp, got.entry_age, got.last);
    end
  endtask

  // Results are checked before the request of the same edge is predicted; a
  // request can never give its result at the edge it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      ring_head = 0;
      ring_fill = 0;
      owed_rsp_q.delete();
      owed = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_rsp_i;
        checked++;
        if (owed_rsp_q.size() == 0) begin
          note_mismatch("no result owed", '0, got);
        end else begin
          want = owed_rsp_q.pop_front();
          if (got.hit !== want.hit || got.entry_stamp !== want.entry_stamp ||
              got.entry_age !== want.entry_age || got.last !== want.last) begin
            note_mismatch("field differs", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_ring_op(in_req_i);
      end
      owed = owed_rsp_q.size();
    end
  end

endmodule

FILE: dv/tb_timestamp_ring_window_match.sv
// ----------------------------------------------------------------------------
// tb_timestamp_ring_window_match
// Drives requests into the timestamp ring under several mixes of sender idling
// and receiver stalling, including one long receiver hold-off, and reports the
// verdict handed back by the checker.
// ----------------------------------------------------------------------------
module tb_timestamp_ring_window_match;

  import trwm_pkg::*;

  localparam int DEPTH          = 16;
  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 350;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 4;
  localparam int WATCHDOG_TIME  = 4_000_000;

  // Opcodes the block ignores.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  req_t        in_req;
  logic        out_valid;
  logic        out_stall;
  rsp_t        out_rsp;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned results;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          holdoff_req    = 0;
  int unsigned op_count [8];

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  timestamp_ring_window_match #(
    .DEPTH (DEPTH)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  trwm_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_rsp_i        (out_rsp),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .results_o        (results)
  );

  // Receiver: random stalls, or a long hold-off counted out here.
  initial begin
    int holdoff_left;
    int holdoff_seen;
    holdoff_left = 0;
    holdoff_seen = 0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        out_stall = 1'b1;
        holdoff_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog.
  initial begin
    #(WATCHDOG_TIME);
    $display("Timeout with %0d results still owed", pending);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Base time for a sequence, now and then close to either end of the range.
  function automatic logic [63:0] pick_base();
    case ($urandom_range(3))
      0: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
      1: return 64'($urandom_range(0, 40));
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [63:0] pick_window();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return rand_word();
      default: return 64'($urandom_range(0, 48));
    endcase
  endfunction

  function automatic logic [63:0] pick_now(logic [63:0] base);
    case ($urandom_range(5))
      0: return base - 64'($urandom_range(1, 20));
      1: return rand_word();
      default: return base + 64'($urandom_range(0, 80));
    endcase
  endfunction

  function automatic int unsigned real_requests();
    return op_count[OP_PUSH] + op_count[OP_PEEK] + op_count[OP_CONSUME] +
           op_count[OP_CLEAR] + op_count[OP_SNAP];
  endfunction

  // Offer one request, after random idle cycles, and hold it until taken.
  task automatic send_request(input logic [2:0] op, input logic [63:0] stamp,
                              input logic [63:0] win);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_req.opcode = op;
    in_req.stamp  = stamp;
    in_req.window = win;
    do @(posedge clk); while (in_stall);
    op_count[op]++;
  endtask

  // A burst of pushes around one base time, then queries near that time.
  task automatic run_sequence();
    logic [63:0] base;
    int          n_push;
    int          n_query;
    logic [2:0]  op;
    base    = pick_base();
    n_push  = $urandom_range(1, 20);
    n_query = $urandom_range(1, 6);
    for (int i = 0; i < n_push; i++) begin
      send_request(OP_PUSH, base + 64'($urandom_range(0, 63)), rand_word());
    end
    for (int i = 0; i < n_query; i++) begin
      case ($urandom_range(2))
        0: op = OP_PEEK;
        1: op = OP_CONSUME;
        default: op = OP_SNAP;
      endcase
      send_request(op, pick_now(base), pick_window());
    end
    if ($urandom_range(3) == 0) begin
      send_request(OP_CLEAR, rand_word(), rand_word());
    end
  endtask

  // Main stimulus.
  initial begin
    int unsigned first_random;
    int unsigned done_random;
    bit          holdoff_done;
    int          n_noise;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    foreach (op_count[i]) op_count[i] = 0;
    holdoff_done = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty ring, extremes of stamp and window, clamped age,
    // removal from the middle, spare opcodes and a clear.
    send_request(OP_SNAP, '0, '0);
    send_request(OP_PEEK, '1, '1);
    send_request(OP_CONSUME, '1, '1);
    send_request(OP_PUSH, '0, '0);
    send_request(OP_PUSH, '1, '1);
    send_request(OP_PUSH, 64'd5, rand_word());
    send_request(OP_PEEK, 64'd5, '0);
    send_request(OP_PEEK, 64'd4, '0);
    send_request(OP_PEEK, '1, '1);
    send_request(OP_CONSUME, '1, '0);
    send_request(OP_SNAP, 64'd3, '0);
    send_request(OP_CONSUME, '0, '0);
    send_request(OP_SPARE_FIRST, '1, '1);
    send_request(OP_SPARE_LAST, '0, '0);
    send_request(OP_SNAP, '1, '1);
    send_request(OP_CLEAR, '1, '1);
    send_request(OP_SNAP, '0, '0);
    send_request(OP_PEEK, '0, '1);

    // Random: mostly well-formed sequences, some noise, in four idle mixes.
    first_random = real_requests();
    done_random  = 0;
    while (done_random < RANDOM_ITEMS) begin
      case (done_random * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (!holdoff_done && done_random >= RANDOM_ITEMS / 8) begin
        holdoff_req++;
        holdoff_done = 1'b1;
      end
      if ($urandom_range(9) < 8) begin
        run_sequence();
      end else begin
        n_noise = $urandom_range(1, 4);
        for (int i = 0; i < n_noise; i++) begin
          send_request(3'($urandom_range(OP_PUSH, OP_SPARE_LAST)), rand_word(),
                       rand_word());
        end
      end
      done_random = real_requests() - first_random;
    end

    @(negedge clk);
    in_valid       = 1'b0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d push, %0d peek, %0d consume, %0d clear, %0d snapshot",
             real_requests(), op_count[OP_PUSH], op_count[OP_PEEK], op_count[OP_CONSUME],
             op_count[OP_CLEAR], op_count[OP_SNAP]);
    $display("plus %0d ignored opcodes; %0d results checked, one %0d-cycle receiver hold-off",
             op_count.sum() - real_requests(), results, HOLDOFF_CYCLES);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
